// File: design/matrix_keypad_gesture_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Keypad gesture detector assertion macros
// Shared property forms for the checker of the keypad gesture detector.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_GESTURE_DETECTOR_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_GESTURE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define MKGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad gesture check failed");

// Next-cycle implication, ignored while reset is held.
`define MKGD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad gesture check failed");

// Next-cycle implication that also covers the reset cycles.
`define MKGD_ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("keypad gesture reset check failed");

`endif

// File: design/mkgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad gesture detector package
// Key code table, decoder, event and register codes.
// ----------------------------------------------------------------------------
package mkgd_pkg;

  typedef logic [4:0] key_t;
  typedef logic [1:0] event_kind_t;
  typedef logic [7:0] ticks_t;

  localparam event_kind_t EV_NONE   = 2'd0;
  localparam event_kind_t EV_SINGLE = 2'd1;
  localparam event_kind_t EV_DOUBLE = 2'd2;
  localparam event_kind_t EV_LONG   = 2'd3;

  localparam logic CFG_LONG_PRESS = 1'b0;
  localparam logic CFG_CLICK_GAP  = 1'b1;

  localparam ticks_t LONG_PRESS_RESET = 8'd100;
  localparam ticks_t CLICK_GAP_RESET  = 8'd10;

  localparam int unsigned NUM_KEYS = 16;

  localparam logic [7:0] KEY_CODES [NUM_KEYS] = '{
    8'hee, 8'hde, 8'hbe, 8'h7e,
    8'hed, 8'hdd, 8'hbd, 8'h7d,
    8'heb, 8'hdb, 8'hbb, 8'h7b,
    8'he7, 8'hd7, 8'hb7, 8'h77
  };

  // Returns the key number 1..16 for a matrix code, 0 for no key or no match.
  function automatic key_t decode_key(input logic [7:0] code);
    key_t k;
    k = '0;
    if (code[3:0] != 4'hf) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (KEY_CODES[i] == code) begin
          k = key_t'(i + 1);
        end
      end
    end
    return k;
  endfunction

endpackage

// File: design/matrix_keypad_gesture_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix keypad gesture detector
// Decodes 4x4 keypad scans into single click, double click and long press.
// ----------------------------------------------------------------------------
// Each input beat is either a scan tick (in_func = 0) carrying the active-low
// matrix code, or a read (in_func = 1) that returns the highest-priority
// pending event (single, then double, then long) with its key and clears it.
// Scans return nothing. Beats land in an input register and pass from there
// into the gesture state and the result register, so the block takes one beat
// per cycle unless a read stalls; a read only stalls while the result register
// still holds a beat the consumer has not taken. A read result goes through the
// input register and then the result register. The user writes hold and gap tick
// counts through the cfg_ port while the block is idle; the block does not enforce it.
module matrix_keypad_gesture_detector_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [7:0]          in_scan_code,
  output logic                out_valid,
  input  logic                out_ready,
  output mkgd_pkg::event_kind_t out_event_kind,
  output mkgd_pkg::key_t      out_key_number,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import mkgd_pkg::*;

  ticks_t long_ticks_r, gap_ticks_r;

  logic       in_valid_r;
  logic       func_r;
  logic [7:0] code_r;

  key_t   cur_key_r, rel_key_r;
  ticks_t rel_cnt_r, hold_cnt_r, rel_before_r;
  logic   single_r, double_r, long_r, in_dbl_r, long_ok_r;

  key_t   cur_key_nxt, rel_key_nxt;
  ticks_t rel_cnt_nxt, hold_cnt_nxt, rel_before_nxt;
  logic   single_nxt, double_nxt, long_nxt, in_dbl_nxt, long_ok_nxt;

  logic        out_valid_r;
  event_kind_t kind_r, kind_nxt;
  key_t        key_r, key_nxt;

  logic out_free, stage_go, do_scan, do_read;
  key_t new_key;

  assign out_free = !out_valid_r || out_ready;
  assign stage_go = !func_r || out_free;
  assign in_ready = !in_valid_r || stage_go;
  assign do_scan  = in_valid_r && !func_r;
  assign do_read  = in_valid_r && func_r && out_free;
  assign new_key  = decode_key(code_r);

  always_comb begin
    cur_key_nxt    = cur_key_r;
    rel_key_nxt    = rel_key_r;
    rel_cnt_nxt    = rel_cnt_r;
    hold_cnt_nxt   = hold_cnt_r;
    rel_before_nxt = rel_before_r;
    single_nxt     = single_r;
    double_nxt     = double_r;
    long_nxt       = long_r;
    in_dbl_nxt     = in_dbl_r;
    long_ok_nxt    = long_ok_r;
    kind_nxt       = EV_NONE;
    key_nxt        = '0;

    if (do_scan) begin
      // The key held before this tick is cur_key_r itself.
      cur_key_nxt  = new_key;
      if (cur_key_r == new_key) begin
        if (new_key == '0) begin
          // Released: count down the gap, then a single click unless long or double.
          if (rel_cnt_r == '0) begin
            if (hold_cnt_r == '0 || in_dbl_r) begin
              rel_before_nxt = '0;
            end else if (rel_before_r == 8'd1) begin
              single_nxt     = 1'b1;
              rel_before_nxt = '0;
            end
          end else begin
            rel_before_nxt = rel_cnt_r;
            rel_cnt_nxt    = rel_cnt_r - 8'd1;
          end
        end else if (hold_cnt_r == '0) begin
          long_nxt = 1'b1;
        end else begin
          hold_cnt_nxt = hold_cnt_r - 8'd1;
        end
      end else if (new_key == '0) begin
        rel_key_nxt = cur_key_r;
        rel_cnt_nxt = gap_ticks_r;
      end else begin
        in_dbl_nxt   = 1'b0;
        long_ok_nxt  = 1'b1;
        hold_cnt_nxt = long_ticks_r;
        // Press in the gap of a short press: other key single, same key double once.
        if (hold_cnt_r != '0 && rel_cnt_r != '0) begin
          if (new_key == rel_key_r) begin
            if (!in_dbl_r) begin
              in_dbl_nxt = 1'b1;
              double_nxt = 1'b1;
            end
          end else begin
            single_nxt = 1'b1;
          end
        end
      end
    end

    if (do_read) begin
      if (single_r) begin
        single_nxt = 1'b0;
        kind_nxt   = EV_SINGLE;
        key_nxt    = rel_key_r;
      end else if (double_r) begin
        double_nxt = 1'b0;
        kind_nxt   = EV_DOUBLE;
        key_nxt    = rel_key_r;
      end else if (long_r) begin
        long_nxt = 1'b0;
        if (long_ok_r) begin
          kind_nxt    = EV_LONG;
          key_nxt     = cur_key_r;
          long_ok_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_PRESS_RESET;
      gap_ticks_r  <= CLICK_GAP_RESET;
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cur_key_r    <= '0;
      rel_key_r    <= '0;
      rel_cnt_r    <= '0;
      hold_cnt_r   <= '0;
      rel_before_r <= '0;
      single_r     <= 1'b0;
      double_r     <= 1'b0;
      long_r       <= 1'b0;
      in_dbl_r     <= 1'b0;
      long_ok_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LONG_PRESS: long_ticks_r <= cfg_wdata;
          CFG_CLICK_GAP:  gap_ticks_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (do_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      cur_key_r    <= cur_key_nxt;
      rel_key_r    <= rel_key_nxt;
      rel_cnt_r    <= rel_cnt_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      rel_before_r <= rel_before_nxt;
      single_r     <= single_nxt;
      double_r     <= double_nxt;
      long_r       <= long_nxt;
      in_dbl_r     <= in_dbl_nxt;
      long_ok_r    <= long_ok_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      func_r <= in_func;
      code_r <= in_scan_code;
    end
    if (do_read) begin
      kind_r <= kind_nxt;
      key_r  <= key_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_key_number = key_r;

endmodule

// File: design/mkgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad gesture detector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_keypad_gesture_detector_top_defines.svh"

module mkgd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input mkgd_pkg::event_kind_t out_event_kind,
  input mkgd_pkg::key_t        out_key_number
);
  import mkgd_pkg::*;

  // A stalled result beat keeps its payload.
  `MKGD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_event_kind) && $stable(out_key_number))

  // An empty result always reports no key.
  `MKGD_ASSERT_IMP(a_none_key, clk, rst_n, out_valid && out_event_kind == EV_NONE, out_key_number == 5'd0)

  // Click events always carry a key number of at most 16.
  `MKGD_ASSERT_IMP(a_click_key, clk, rst_n, out_valid && (out_event_kind == EV_SINGLE || out_event_kind == EV_DOUBLE), out_key_number <= 5'd16)

  // Reset empties the result register.
  `MKGD_ASSERT_NXT_ALL(a_reset, clk, !rst_n, !out_valid)

endmodule

bind matrix_keypad_gesture_detector_top mkgd_checker u_mkgd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_kind (out_event_kind),
  .out_key_number (out_key_number)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad gesture detector testbench
// Drives scan and read beats into the gesture detector and tracks the gesture
// state alongside it, so that every event it returns is checked against the
// event predicted at the time the read beat was accepted.
// ----------------------------------------------------------------------------
module tb;
  import mkgd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_OFF_LEN  = 80;

  localparam logic FN_SCAN = 1'b0;
  localparam logic FN_READ = 1'b1;

  typedef struct packed {
    event_kind_t kind;
    key_t        key;
  } gesture_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        in_func      = FN_SCAN;
  logic [7:0]  in_scan_code = 8'hff;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  event_kind_t out_event_kind;
  key_t        out_key_number;
  logic        cfg_wr_en    = 1'b0;
  logic        cfg_index    = CFG_LONG_PRESS;
  logic [7:0]  cfg_wdata    = 8'h00;

  // Tracked gesture state and register copies.
  ticks_t hold_reload;
  ticks_t gap_reload;
  key_t   prior_key;
  key_t   held_key;
  key_t   released_key;
  ticks_t gap_left;
  ticks_t hold_left;
  ticks_t gap_left_prior;
  bit     want_single;
  bit     want_double;
  bit     want_long;
  bit     double_armed;
  bit     long_ok;

  gesture_t    expected_gestures[$];
  gesture_t    oldest_gesture;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned beats_sent    = 0;
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_off_left = 0;

  matrix_keypad_gesture_detector_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_scan_code   (in_scan_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_number (out_key_number),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Key k sits at row (k-1)/4 and column (k-1)%4; both nibbles are active low.
  function automatic logic [7:0] code_of_key(int unsigned k);
    int unsigned row;
    int unsigned col;
    row = (k - 1) / 4;
    col = (k - 1) % 4;
    return {~(4'b0001 << col), ~(4'b0001 << row)};
  endfunction

  function automatic key_t key_of_code(logic [7:0] code);
    key_t k;
    k = '0;
    if (code[3:0] != 4'hf) begin
      for (int unsigned i = 1; i <= NUM_KEYS; i++) begin
        if (code_of_key(i) == code) begin
          k = key_t'(i);
        end
      end
    end
    return k;
  endfunction

  function automatic void track_scan(logic [7:0] code);
    bit was_double;
    prior_key = held_key;
    held_key  = key_of_code(code);
    if (prior_key == held_key) begin
      if (held_key == 0) begin
        if (gap_left == 0) begin
          // A click that ended in a long press or a double click commits nothing.
          if (hold_left == 0 || double_armed) begin
            gap_left_prior = '0;
          end else if (gap_left_prior == 1) begin
            want_single    = 1'b1;
            gap_left_prior = '0;
          end
        end else begin
          gap_left_prior = gap_left;
          gap_left       = gap_left - 1'b1;
        end
      end else if (hold_left == 0) begin
        want_long = 1'b1;
      end else begin
        hold_left = hold_left - 1'b1;
      end
    end else if (held_key == 0) begin
      released_key = prior_key;
      gap_left     = gap_reload;
    end else begin
      was_double   = double_armed;
      double_armed = 1'b0;
      long_ok      = 1'b1;
      if (hold_left == 0) begin
        hold_left = hold_reload;
      end else begin
        hold_left = hold_reload;
        if (gap_left != 0) begin
          if (held_key != released_key) begin
            want_single = 1'b1;
          end else if (!was_double) begin
            double_armed = 1'b1;
            want_double  = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic gesture_t take_gesture();
    gesture_t g;
    g.kind = EV_NONE;
    g.key  = '0;
    if (want_single) begin
      want_single = 1'b0;
      g.kind      = EV_SINGLE;
      g.key       = released_key;
    end else if (want_double) begin
      want_double = 1'b0;
      g.kind      = EV_DOUBLE;
      g.key       = released_key;
    end else if (want_long) begin
      want_long = 1'b0;
      if (long_ok) begin
        g.kind  = EV_LONG;
        g.key   = held_key;
        long_ok = 1'b0;
      end
    end
    return g;
  endfunction

  // Offers one beat after a random gap and tracks it once it is accepted.
  task automatic send_beat(logic func, logic [7:0] code);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid     <= 1'b0;
      in_func      <= 1'($urandom_range(0, 1));
      in_scan_code <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_scan_code <= code;
    do @(posedge clk); while (!in_ready);
    if (func == FN_READ) begin
      expected_gestures.push_back(take_gesture());
    end else begin
      track_scan(code);
    end
    beats_sent++;
  endtask

  task automatic write_reg(logic idx, ticks_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_LONG_PRESS) begin
      hold_reload = value;
    end else begin
      gap_reload = value;
    end
  endtask

  // Scans leave no result behind, so the SETTLE_CYCLES wait covers one still in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_gestures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_read();
    send_beat(FN_READ, 8'($urandom_range(0, 255)));
  endtask

  // Press, hold and release sequences with reads sprinkled in, plus some noise.
  task automatic play_gestures(int unsigned count);
    int unsigned stop_at;
    int unsigned k;
    int unsigned held;
    int unsigned gaps;
    int unsigned last_key;
    stop_at  = beats_sent + count;
    last_key = 0;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        k    = (last_key != 0 && $urandom_range(0, 2) == 0) ? last_key
                                                           : $urandom_range(1, 16);
        held = $urandom_range(1, (hold_reload > 20) ? 24 : hold_reload + 3);
        repeat (held) begin
          send_beat(FN_SCAN, code_of_key(k));
          if ($urandom_range(0, 7) == 0) send_read();
        end
        gaps = $urandom_range(0, (gap_reload > 9) ? 12 : gap_reload + 3);
        repeat (gaps) begin
          send_beat(FN_SCAN, ($urandom_range(0, 3) == 0) ?
                    {4'($urandom_range(0, 15)), 4'hf} : 8'hff);
          if ($urandom_range(0, 7) == 0) send_read();
        end
        if ($urandom_range(0, 1) == 0) send_read();
        last_key = k;
      end
    end
  endtask

  task automatic test_directed();
    // Nothing pending yet, then the no-key codes at reset register values.
    send_read();
    send_beat(FN_SCAN, 8'hff);
    send_beat(FN_SCAN, 8'h0f);
    send_beat(FN_SCAN, 8'hf0);
    send_beat(FN_SCAN, 8'h00);
    wait_idle();
    write_reg(CFG_LONG_PRESS, 8'd3);
    write_reg(CFG_CLICK_GAP, 8'd2);
    // Hold key 1 into a long press, then read it twice: the second is refused.
    repeat (5) send_beat(FN_SCAN, code_of_key(1));
    send_read();
    send_beat(FN_SCAN, code_of_key(1));
    send_read();
    // Key 16 tapped twice inside the gap is a double click.
    send_beat(FN_SCAN, 8'hff);
    send_beat(FN_SCAN, code_of_key(16));
    send_beat(FN_SCAN, 8'hff);
    send_beat(FN_SCAN, code_of_key(16));
    send_read();
    // The release after a double click commits no single click.
    repeat (3) send_beat(FN_SCAN, 8'hff);
    // A plain tap of key 2 that runs out the gap is a single click.
    send_beat(FN_SCAN, code_of_key(2));
    repeat (4) send_beat(FN_SCAN, 8'hff);
    send_read();
    wait_idle();
  endtask

  task automatic test_idle_phases();
    for (int unsigned p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_reg(CFG_LONG_PRESS, 8'd1);
          write_reg(CFG_CLICK_GAP, 8'd255);
        end
        1: begin
          idle_pct  = 48;
          stall_pct = 0;
          write_reg(CFG_LONG_PRESS, 8'd255);
          write_reg(CFG_CLICK_GAP, 8'd1);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 48;
          write_reg(CFG_LONG_PRESS, 8'($urandom_range(2, 12)));
          write_reg(CFG_CLICK_GAP, 8'($urandom_range(2, 8)));
        end
        default: begin
          idle_pct  = 34;
          stall_pct = 34;
          write_reg(CFG_LONG_PRESS, 8'($urandom_range(1, 6)));
          write_reg(CFG_CLICK_GAP, 8'($urandom_range(1, 5)));
        end
      endcase
      play_gestures(90);
      wait_idle();
    end
  endtask

  // The receiver holds off while reads keep coming, so the block backs up.
  task automatic test_back_pressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_LONG_PRESS, 8'($urandom_range(1, 8)));
    write_reg(CFG_CLICK_GAP, 8'($urandom_range(1, 6)));
    play_gestures(15);
    hold_off_left = HOLD_OFF_LEN;
    repeat (12) begin
      send_read();
      send_beat(FN_SCAN, code_of_key($urandom_range(1, 16)));
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      out_ready     <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_gestures.size() == 0) begin
        $display("%0t: result beat with none expected: kind %0d key %0d",
                 $time, out_event_kind, out_key_number);
        mismatches++;
      end else begin
        oldest_gesture = expected_gestures.pop_front();
        if (out_event_kind !== oldest_gesture.kind) begin
          $display("%0t: event_kind expected %0d actual %0d",
                   $time, oldest_gesture.kind, out_event_kind);
          mismatches++;
        end
        if (out_key_number !== oldest_gesture.key) begin
          $display("%0t: key_number expected %0d actual %0d",
                   $time, oldest_gesture.key, out_key_number);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    hold_reload    = LONG_PRESS_RESET;
    gap_reload     = CLICK_GAP_RESET;
    prior_key      = '0;
    held_key       = '0;
    released_key   = '0;
    gap_left       = '0;
    hold_left      = '0;
    gap_left_prior = '0;
    want_single    = 1'b0;
    want_double    = 1'b0;
    want_long      = 1'b0;
    double_armed   = 1'b0;
    long_ok        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idle_phases();
    test_back_pressure();
    if (mismatches == 0 && expected_gestures.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
